@@ sv/fixed_timeout_timer_wheel_top_defines.svh @@
// assertion macros for the timer wheel checker
`ifndef FIXED_TIMEOUT_TIMER_WHEEL_TOP_DEFINES_SVH
`define FIXED_TIMEOUT_TIMER_WHEEL_TOP_DEFINES_SVH

// same-cycle implication
`define FTW_ASSERT_IMPL(name, pre, post, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define FTW_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ sv/ftw_pkg.sv @@
package ftw_pkg;

    localparam int MAX_TIMERS   = 32;
    localparam int WHEEL_DEPTH  = 1024;
    localparam int PAYLOAD_BITS = 32;

    localparam int IDX_W   = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CNT_W   = $clog2(MAX_TIMERS + 1);
    localparam int SLOT_W  = $clog2(WHEEL_DEPTH);
    localparam int SLOTS_W = 11;
    localparam int ID_W    = 32;
    localparam int WORD_W  = 32;
    localparam int FIELD_CNT_W = 6;

    localparam logic [SLOTS_W-1:0] SLOTS_RESET = SLOTS_W'(1000);

    typedef enum logic [1:0] {
        ACT_ADD  = 2'd0,
        ACT_GET  = 2'd1,
        ACT_DEL  = 2'd2,
        ACT_TICK = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        K_ADD  = 3'd0,
        K_GET  = 3'd1,
        K_DEL  = 3'd2,
        K_EXP  = 3'd3,
        K_DONE = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_NOTFD = 2'd2
    } t_status;

    typedef struct packed {
        logic [ID_W-1:0]         id;
        logic [SLOT_W-1:0]       slot;
        logic [PAYLOAD_BITS-1:0] data;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        t_kind                  kind;
        t_status                status;
        logic [ID_W-1:0]        id;
        logic [WORD_W-1:0]      payload;
        logic [FIELD_CNT_W-1:0] exp_cnt;
        logic [FIELD_CNT_W-1:0] live;
        logic                   last;
    } t_res;

endpackage

@@ sv/ftw_ram.sv @@
module ftw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/ftw_seq.sv @@
module ftw_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [ftw_pkg::SLOTS_W-1:0] i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_action,
    input  logic [ftw_pkg::ID_W-1:0]    i_timer_id,
    input  logic [ftw_pkg::WORD_W-1:0]  i_payload,
    output logic                        o_ram_we,
    output logic [ftw_pkg::IDX_W-1:0]   o_ram_waddr,
    output ftw_pkg::t_entry             o_ram_wdata,
    output logic                        o_ram_re,
    output logic [ftw_pkg::IDX_W-1:0]   o_ram_raddr,
    input  ftw_pkg::t_entry             i_ram_rdata,
    output logic                        o_push,
    output ftw_pkg::t_res               o_res,
    input  logic                        i_free
);
    import ftw_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_FIND_RD  = 9'b000000010,
        S_FIND_CHK = 9'b000000100,
        S_SHIFT_RD = 9'b000001000,
        S_SHIFT_WR = 9'b000010000,
        S_CNT      = 9'b000100000,
        S_EXP_RD   = 9'b001000000,
        S_EXP_CHK  = 9'b010000000,
        S_REPLY    = 9'b100000000
    } t_state;

    t_state               r_state;
    logic [SLOTS_W-1:0]   r_slots;
    logic [SLOT_W-1:0]    r_pos;
    logic [ID_W-1:0]      r_next_id;
    logic [CNT_W-1:0]     r_live;
    logic [CNT_W-1:0]     r_old;
    logic [CNT_W-1:0]     r_idx;
    logic [CNT_W-1:0]     r_wr;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_pend;
    t_action              r_act;
    logic [ID_W-1:0]      r_tid;
    t_res                 r_rep;

    logic                 in_acc;
    t_action              act;
    logic [ID_W-1:0]      add_id;
    logic [CNT_W-1:0]     idx_inc;
    logic [SLOTS_W-1:0]   eff_slots;
    logic [SLOTS_W-1:0]   pos_inc;
    logic [SLOT_W-1:0]    pos_new;
    logic                 slot_hit;
    t_kind                miss_kind;

    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign act        = t_action'(i_action);
    assign idx_inc    = r_idx + CNT_W'(1);
    assign slot_hit   = (i_ram_rdata.slot == r_pos);
    assign miss_kind  = (r_act == ACT_GET) ? K_GET : K_DEL;

    always_comb begin
        add_id = r_next_id + ID_W'(1);
        if (add_id == '0) begin
            add_id = ID_W'(1);
        end
    end

    // clamp the slot count to 1..WHEEL_DEPTH
    always_comb begin
        if (r_slots == '0) begin
            eff_slots = SLOTS_W'(1);
        end else if (r_slots > SLOTS_W'(WHEEL_DEPTH)) begin
            eff_slots = SLOTS_W'(WHEEL_DEPTH);
        end else begin
            eff_slots = r_slots;
        end
        pos_inc = SLOTS_W'(r_pos) + SLOTS_W'(1);
        if (pos_inc >= eff_slots) begin
            pos_new = '0;
        end else begin
            pos_new = pos_inc[SLOT_W-1:0];
        end
    end

    // memory port and result push
    always_comb begin
        o_ram_we    = 1'b0;
        o_ram_waddr = r_idx[IDX_W-1:0];
        o_ram_wdata = i_ram_rdata;
        o_ram_re    = 1'b0;
        o_ram_raddr = r_idx[IDX_W-1:0];
        o_push      = 1'b0;
        o_res       = r_rep;
        o_res.live  = FIELD_CNT_W'(r_live);
        case (r_state)
            S_IDLE: begin
                if (in_acc && act == ACT_ADD && r_live < CNT_W'(MAX_TIMERS)) begin
                    o_ram_we         = 1'b1;
                    o_ram_waddr      = r_live[IDX_W-1:0];
                    o_ram_wdata.id   = add_id;
                    o_ram_wdata.slot = r_pos;
                    o_ram_wdata.data = PAYLOAD_BITS'(i_payload);
                end
            end
            S_FIND_RD: begin
                o_ram_re = 1'b1;
            end
            S_SHIFT_RD: begin
                o_ram_re    = (idx_inc < r_live);
                o_ram_raddr = idx_inc[IDX_W-1:0];
            end
            S_SHIFT_WR: begin
                o_ram_we = 1'b1;
            end
            S_CNT: begin
                o_ram_re = (r_idx < r_old);
            end
            S_EXP_RD: begin
                o_ram_re = (r_idx < r_old);
            end
            S_EXP_CHK: begin
                if (!slot_hit) begin
                    o_ram_we    = 1'b1;
                    o_ram_waddr = r_wr[IDX_W-1:0];
                end else begin
                    o_push        = i_free;
                    o_res.kind    = K_EXP;
                    o_res.status  = ST_OK;
                    o_res.id      = i_ram_rdata.id;
                    o_res.payload = WORD_W'(i_ram_rdata.data);
                    o_res.exp_cnt = '0;
                    o_res.last    = 1'b0;
                end
            end
            S_REPLY: begin
                o_push = i_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_slots   <= SLOTS_RESET;
            r_pos     <= '0;
            r_next_id <= '0;
            r_live    <= '0;
            r_pend    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_slots <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_act         <= act;
                        r_tid         <= i_timer_id;
                        r_idx         <= '0;
                        r_rep.payload <= '0;
                        r_rep.exp_cnt <= '0;
                        r_rep.last    <= 1'b1;
                        r_rep.live    <= '0;
                        case (act)
                            ACT_ADD: begin
                                r_next_id  <= add_id;
                                r_rep.kind <= K_ADD;
                                if (r_live < CNT_W'(MAX_TIMERS)) begin
                                    r_live       <= r_live + CNT_W'(1);
                                    r_rep.status <= ST_OK;
                                    r_rep.id     <= add_id;
                                end else begin
                                    r_rep.status <= ST_FULL;
                                    r_rep.id     <= '0;
                                end
                                r_state <= S_REPLY;
                            end
                            ACT_GET, ACT_DEL: begin
                                r_rep.kind <= (act == ACT_GET) ? K_GET : K_DEL;
                                r_rep.id   <= '0;
                                if (r_live == '0) begin
                                    r_rep.status <= ST_NOTFD;
                                    r_state      <= S_REPLY;
                                end else begin
                                    r_rep.status <= ST_OK;
                                    r_state      <= S_FIND_RD;
                                end
                            end
                            ACT_TICK: begin
                                r_rep.status <= ST_OK;
                                r_rep.id     <= '0;
                                r_pos        <= pos_new;
                                r_old        <= r_live;
                                r_cnt        <= '0;
                                r_pend       <= 1'b0;
                                r_state      <= S_CNT;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_FIND_RD: begin
                    r_state <= S_FIND_CHK;
                end
                S_FIND_CHK: begin
                    if (i_ram_rdata.id == r_tid) begin
                        r_rep.id <= r_tid;
                        if (r_act == ACT_GET) begin
                            r_rep.payload <= WORD_W'(i_ram_rdata.data);
                            r_state       <= S_REPLY;
                        end else begin
                            r_state <= S_SHIFT_RD;
                        end
                    end else if (idx_inc >= r_live) begin
                        r_rep.kind   <= miss_kind;
                        r_rep.status <= ST_NOTFD;
                        r_state      <= S_REPLY;
                    end else begin
                        r_idx   <= idx_inc;
                        r_state <= S_FIND_RD;
                    end
                end
                S_SHIFT_RD: begin
                    if (idx_inc < r_live) begin
                        r_state <= S_SHIFT_WR;
                    end else begin
                        r_live  <= r_live - CNT_W'(1);
                        r_state <= S_REPLY;
                    end
                end
                S_SHIFT_WR: begin
                    r_idx   <= idx_inc;
                    r_state <= S_SHIFT_RD;
                end
                S_CNT: begin
                    if (r_pend && slot_hit) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                    if (r_idx < r_old) begin
                        r_idx  <= idx_inc;
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                        if (!r_pend) begin
                            r_idx   <= '0;
                            r_wr    <= '0;
                            r_live  <= r_old - r_cnt;
                            r_state <= S_EXP_RD;
                        end
                    end
                end
                S_EXP_RD: begin
                    if (r_idx < r_old) begin
                        r_state <= S_EXP_CHK;
                    end else begin
                        r_rep.kind    <= K_DONE;
                        r_rep.exp_cnt <= FIELD_CNT_W'(r_cnt);
                        r_state       <= S_REPLY;
                    end
                end
                S_EXP_CHK: begin
                    if (!slot_hit) begin
                        r_wr    <= r_wr + CNT_W'(1);
                        r_idx   <= idx_inc;
                        r_state <= S_EXP_RD;
                    end else if (i_free) begin
                        r_idx   <= idx_inc;
                        r_state <= S_EXP_RD;
                    end
                end
                S_REPLY: begin
                    if (i_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ sv/ftw_out.sv @@
module ftw_out (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  ftw_pkg::t_res                   i_res,
    output logic                            o_free,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [2:0]                      o_kind,
    output logic [1:0]                      o_status,
    output logic [ftw_pkg::ID_W-1:0]        o_result_id,
    output logic [ftw_pkg::WORD_W-1:0]      o_result_payload,
    output logic [ftw_pkg::FIELD_CNT_W-1:0] o_expired_count,
    output logic [ftw_pkg::FIELD_CNT_W-1:0] o_live_count,
    output logic                            o_last
);
    import ftw_pkg::*;

    logic r_vld;
    t_res r_res;

    assign o_free = !r_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_push) begin
            r_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid      = r_vld;
    assign o_kind           = r_res.kind;
    assign o_status         = r_res.status;
    assign o_result_id      = r_res.id;
    assign o_result_payload = r_res.payload;
    assign o_expired_count  = r_res.exp_cnt;
    assign o_live_count     = r_res.live;
    assign o_last           = r_res.last;

endmodule

@@ sv/fixed_timeout_timer_wheel_top.sv @@
// timer wheel, one request at a time, timers packed in one 32-entry ram
// add: result registered in the reply state, then in the output register; get: ram read/check per entry
// delete: search as for get, then compaction by ram read/write pairs
// tick: one pass to count due timers, then a ram read/check per timer to expire or compact
// next request accepted once the last result sits in the output register
// synchronous active-low reset: empty table, position 0, id 0, slots 1000
module fixed_timeout_timer_wheel_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ftw_pkg::SLOTS_W-1:0]     i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_action,
    input  logic [ftw_pkg::ID_W-1:0]        i_timer_id,
    input  logic [ftw_pkg::WORD_W-1:0]      i_payload,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [2:0]                      o_kind,
    output logic [1:0]                      o_status,
    output logic [ftw_pkg::ID_W-1:0]        o_result_id,
    output logic [ftw_pkg::WORD_W-1:0]      o_result_payload,
    output logic [ftw_pkg::FIELD_CNT_W-1:0] o_expired_count,
    output logic [ftw_pkg::FIELD_CNT_W-1:0] o_live_count,
    output logic                            o_last
);
    import ftw_pkg::*;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    t_entry           ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    t_entry           ram_rdata;
    logic             push;
    t_res             res;
    logic             free;

    ftw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TIMERS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ftw_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_timer_id  (i_timer_id),
        .i_payload   (i_payload),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_push      (push),
        .o_res       (res),
        .i_free      (free)
    );

    ftw_out u_out (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .i_res            (res),
        .o_free           (free),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_kind           (o_kind),
        .o_status         (o_status),
        .o_result_id      (o_result_id),
        .o_result_payload (o_result_payload),
        .o_expired_count  (o_expired_count),
        .o_live_count     (o_live_count),
        .o_last           (o_last)
    );

endmodule

@@ sv/ftw_chk.sv @@
`include "fixed_timeout_timer_wheel_top_defines.svh"

module ftw_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [2:0]                      o_kind,
    input logic [ftw_pkg::ID_W-1:0]        o_result_id,
    input logic [ftw_pkg::WORD_W-1:0]      o_result_payload,
    input logic [ftw_pkg::FIELD_CNT_W-1:0] o_expired_count,
    input logic [ftw_pkg::FIELD_CNT_W-1:0] o_live_count,
    input logic                            o_last
);
    import ftw_pkg::*;

    `FTW_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_kind) && $stable(o_result_id) && $stable(o_result_payload), "stalled result changed")

    `FTW_ASSERT_NEXT(a_busy_after_req, i_in_valid && !o_in_stall, o_in_stall, "second request taken while busy")

    `FTW_ASSERT_IMPL(a_last_kind, o_out_valid, o_last == (o_kind != K_EXP), "last flag does not match result kind")

    `FTW_ASSERT_IMPL(a_count_kind, o_out_valid && o_expired_count != '0, o_kind == K_DONE, "expired count outside tick done")

    `FTW_ASSERT_IMPL(a_live_bound, o_out_valid, o_live_count <= FIELD_CNT_W'(MAX_TIMERS), "live count above table size")

endmodule

bind fixed_timeout_timer_wheel_top ftw_chk u_chk (.*);

@@ test/tb_fixed_timeout_timer_wheel_top.sv @@
module tb_fixed_timeout_timer_wheel_top;
    import ftw_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned HOLD_CYCLES = 600;
    localparam int unsigned DRAIN_CYCLES = 120;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [SLOTS_W-1:0]     i_cfg_wdata;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic [1:0]             i_action;
    logic [ID_W-1:0]        i_timer_id;
    logic [WORD_W-1:0]      i_payload;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic [2:0]             o_kind;
    logic [1:0]             o_status;
    logic [ID_W-1:0]        o_result_id;
    logic [WORD_W-1:0]      o_result_payload;
    logic [FIELD_CNT_W-1:0] o_expired_count;
    logic [FIELD_CNT_W-1:0] o_live_count;
    logic                   o_last;

    fixed_timeout_timer_wheel_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_timer_id       (i_timer_id),
        .i_payload        (i_payload),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_kind           (o_kind),
        .o_status         (o_status),
        .o_result_id      (o_result_id),
        .o_result_payload (o_result_payload),
        .o_expired_count  (o_expired_count),
        .o_live_count     (o_live_count),
        .o_last           (o_last)
    );

    always #5 i_clk = ~i_clk;

    // timer table as the block should hold it, packed in insertion order
    logic [ID_W-1:0]         tmr_id   [MAX_TIMERS];
    logic [SLOT_W-1:0]       tmr_slot [MAX_TIMERS];
    logic [PAYLOAD_BITS-1:0] tmr_data [MAX_TIMERS];
    int                      live_n;
    logic [SLOT_W-1:0]       wheel_pos;
    logic [ID_W-1:0]         id_counter;
    logic [SLOTS_W-1:0]      slots_reg;

    t_res        expected_results[$];
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned in_idle_pct = 0;
    int unsigned out_stall_pct = 0;
    logic        hold_go = 1'b0;
    int unsigned hold_left = 0;

    function automatic void reset_wheel_model();
        live_n = 0;
        wheel_pos = '0;
        id_counter = '0;
        slots_reg = SLOTS_RESET;
        expected_results.delete();
    endfunction

    function automatic void predict_request(t_action act, logic [ID_W-1:0] tid,
                                            logic [WORD_W-1:0] pay);
        t_res outs[$];
        t_res r;
        int   hit;
        int   eff;
        int   p;
        int   kept;
        int   n_exp;
        hit = -1;
        r = '0;
        r.last = 1'b1;
        case (act)
            ACT_ADD: begin
                id_counter++;
                if (id_counter == 0)
                    id_counter++;
                r.kind = K_ADD;
                if (live_n >= MAX_TIMERS) begin
                    r.status = ST_FULL;
                end else begin
                    tmr_id[live_n] = id_counter;
                    tmr_slot[live_n] = wheel_pos;
                    tmr_data[live_n] = pay;
                    live_n++;
                    r.id = id_counter;
                end
                outs.push_back(r);
            end
            ACT_GET, ACT_DEL: begin
                for (int i = 0; i < live_n; i++)
                    if (hit < 0 && tmr_id[i] == tid)
                        hit = i;
                if (act == ACT_GET)
                    r.kind = K_GET;
                else
                    r.kind = K_DEL;
                if (hit < 0) begin
                    r.status = ST_NOTFD;
                end else begin
                    r.id = tid;
                    if (act == ACT_GET) begin
                        r.payload = tmr_data[hit];
                    end else begin
                        for (int i = hit; i + 1 < live_n; i++) begin
                            tmr_id[i] = tmr_id[i + 1];
                            tmr_slot[i] = tmr_slot[i + 1];
                            tmr_data[i] = tmr_data[i + 1];
                        end
                        live_n--;
                    end
                end
                outs.push_back(r);
            end
            default: begin
                eff = int'(slots_reg);
                if (eff == 0)
                    eff = 1;
                if (eff > WHEEL_DEPTH)
                    eff = WHEEL_DEPTH;
                p = int'(wheel_pos) + 1;
                if (p >= eff)
                    p = 0;
                wheel_pos = p[SLOT_W-1:0];
                kept = 0;
                n_exp = 0;
                for (int i = 0; i < live_n; i++) begin
                    if (tmr_slot[i] == wheel_pos) begin
                        r = '0;
                        r.kind = K_EXP;
                        r.id = tmr_id[i];
                        r.payload = tmr_data[i];
                        outs.push_back(r);
                        n_exp++;
                    end else begin
                        tmr_id[kept] = tmr_id[i];
                        tmr_slot[kept] = tmr_slot[i];
                        tmr_data[kept] = tmr_data[i];
                        kept++;
                    end
                end
                live_n = kept;
                r = '0;
                r.kind = K_DONE;
                r.exp_cnt = FIELD_CNT_W'(n_exp);
                r.last = 1'b1;
                outs.push_back(r);
            end
        endcase
        foreach (outs[k]) begin
            r = outs[k];
            r.live = FIELD_CNT_W'(live_n);
            expected_results.push_back(r);
        end
    endfunction

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: mismatch: %s", $time, msg);
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
            note_failure($sformatf("%s expected %h got %h", name, want, got));
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (expected_results.size() == 0) begin
                note_failure($sformatf("result with none pending, kind %0d id %h",
                                       o_kind, o_result_id));
            end else begin
                want = expected_results.pop_front();
                compare_field("kind", 32'(want.kind), 32'(o_kind));
                compare_field("status", 32'(want.status), 32'(o_status));
                compare_field("result_id", want.id, o_result_id);
                compare_field("result_payload", want.payload, o_result_payload);
                compare_field("expired_count", 32'(want.exp_cnt), 32'(o_expired_count));
                compare_field("live_count", 32'(want.live), 32'(o_live_count));
                compare_field("last", 32'(want.last), 32'(o_last));
            end
        end
    end

    // receiver stall: random, plus a long hold-off when hold_go is set
    always @(posedge i_clk) begin
        if (hold_go) begin
            hold_go = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("fixed_timeout_timer_wheel_top regression: fail");
            $finish;
        end
    end

    task automatic send_request(t_action act, logic [ID_W-1:0] tid, logic [WORD_W-1:0] pay);
        while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action <= act;
        i_timer_id <= tid;
        i_payload <= pay;
        do
            @(posedge i_clk);
        while (o_in_stall !== 1'b0);
        predict_request(act, tid, pay);
    endtask

    task automatic settle_idle();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_wheel_slots(logic [SLOTS_W-1:0] value);
        settle_idle();
        repeat (3) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        slots_reg = value;
        i_cfg_we <= 1'b0;
    endtask

    task automatic tick_wheel(int unsigned n);
        repeat (n) send_request(ACT_TICK, $urandom, $urandom);
    endtask

    task automatic add_timers(int unsigned n);
        repeat (n) send_request(ACT_ADD, $urandom, $urandom);
    endtask

    task automatic drain_timers();
        while (live_n != 0)
            send_request(ACT_DEL, tmr_id[0], $urandom);
    endtask

    task automatic test_basic_ops();
        logic [ID_W-1:0] mid_id;
        logic [ID_W-1:0] tail_id;
        send_request(ACT_ADD, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(ACT_ADD, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(ACT_ADD, 32'h1234_5678, 32'hA5A5_5A5A);
        mid_id = tmr_id[1];
        tail_id = tmr_id[2];
        send_request(ACT_GET, mid_id, 32'h0);
        send_request(ACT_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(ACT_GET, 32'hFFFF_FFFF, 32'h0);
        send_request(ACT_DEL, mid_id, 32'h0);
        send_request(ACT_DEL, mid_id, 32'h0);
        send_request(ACT_GET, tail_id, 32'h0);
        send_request(ACT_DEL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // nothing due yet
        send_request(ACT_TICK, 32'h0, 32'h0);
        send_request(ACT_ADD, 32'h0, 32'h5A5A_A5A5);
    endtask

    task automatic test_default_timeout();
        // well short of the default timeout, nothing may expire
        tick_wheel(12);
    endtask

    task automatic test_table_full();
        add_timers(34);
        send_request(ACT_TICK, 32'h0, 32'h0);
        send_request(ACT_GET, tmr_id[MAX_TIMERS-1], 32'h0);
        send_request(ACT_DEL, tmr_id[0], 32'h0);
        add_timers(2);
        drain_timers();
    endtask

    task automatic test_wheel_extremes();
        // zero acts as one: every tick returns the position to slot 0
        write_wheel_slots(11'd0);
        add_timers(MAX_TIMERS);
        tick_wheel(1);
        add_timers(1);
        tick_wheel(2);
        write_wheel_slots(11'd1);
        add_timers(3);
        tick_wheel(1);
        write_wheel_slots(11'd1024);
        add_timers(2);
        tick_wheel(8);
        // above the wheel depth
        write_wheel_slots(11'd2047);
        add_timers(1);
        tick_wheel(8);
    endtask

    task automatic test_resize_with_live();
        logic [ID_W-1:0] stranded_id;
        drain_timers();
        write_wheel_slots(11'd16);
        tick_wheel(12);
        add_timers(2);
        tick_wheel(1);
        add_timers(1);
        stranded_id = tmr_id[0];
        // shrink below both position and stored slots
        write_wheel_slots(11'd4);
        tick_wheel(8);
        add_timers(1);
        tick_wheel(4);
        send_request(ACT_GET, stranded_id, 32'h0);
        send_request(ACT_GET, tmr_id[2], 32'h0);
        drain_timers();
    endtask

    task automatic test_backpressure();
        write_wheel_slots(11'd3);
        hold_go = 1'b1;
        repeat (20) begin
            send_request(ACT_ADD, $urandom, $urandom);
            send_request(ACT_TICK, $urandom, $urandom);
        end
        settle_idle();
    endtask

    task automatic run_random_phase(int unsigned n_items, logic [SLOTS_W-1:0] slots,
                                    int unsigned in_pct, int unsigned out_pct);
        int unsigned     pick;
        logic [ID_W-1:0] tid;
        drain_timers();
        write_wheel_slots(slots);
        in_idle_pct = in_pct;
        out_stall_pct = out_pct;
        repeat (n_items) begin
            pick = $urandom_range(99);
            if (live_n != 0 && $urandom_range(3) != 0)
                tid = tmr_id[$urandom_range(live_n - 1)];
            else
                tid = $urandom;
            if (pick < 40)
                send_request(ACT_ADD, $urandom, $urandom);
            else if (pick < 58)
                send_request(ACT_GET, tid, $urandom);
            else if (pick < 72)
                send_request(ACT_DEL, tid, $urandom);
            else
                send_request(ACT_TICK, $urandom, $urandom);
        end
        settle_idle();
        in_idle_pct = 0;
        out_stall_pct = 0;
    endtask

    task automatic test_random_mix();
        run_random_phase(45, 11'd6, 0, 0);
        run_random_phase(45, 11'd1, 87, 0);
        run_random_phase(45, 11'd23, 0, 87);
        run_random_phase(45, 11'd2047, 38, 38);
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= '0;
        i_in_valid <= 1'b0;
        i_action <= ACT_ADD;
        i_timer_id <= '0;
        i_payload <= '0;
        reset_wheel_model();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_ops();
        test_default_timeout();
        test_table_full();
        test_wheel_extremes();
        test_resize_with_live();
        test_backpressure();
        test_random_mix();
        settle_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0)
            note_failure($sformatf("%0d results never arrived", expected_results.size()));
        if (fail_count == 0)
            $display("fixed_timeout_timer_wheel_top regression: pass");
        else
            $display("fixed_timeout_timer_wheel_top regression: fail");
        $finish;
    end

endmodule
